// ===== rtl/ttm_pkg.sv =====
// Shared constants, register indexes and types of the trigger to throttle mapper.
package ttm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int Q_FRAC      = 16;
  localparam int QW          = SAMPLE_BITS + Q_FRAC;
  localparam int FR_W        = Q_FRAC + 1;
  localparam int TH_W        = 16;
  localparam int SPD_W       = 2;
  localparam int MUL_W       = 7;
  localparam int BRAKE_SH    = 7;
  localparam int DV_W        = TH_W + MUL_W;
  localparam int THR_W       = 8;
  localparam int DQ          = THR_W;
  localparam int RC_W        = 11;
  localparam int IN_W        = ((SAMPLE_BITS + SPD_W + 7) / 8) * 8;
  localparam int OUT_W       = ((THR_W + RC_W + SPD_W + 1 + 7) / 8) * 8;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 16;
  localparam int QD          = 4;
  localparam int QP_W        = 2;
  localparam int QC_W        = QP_W + 1;

  localparam logic [FR_W-1:0]  Q_ONE      = {1'b1, {Q_FRAC{1'b0}}};
  localparam logic [MUL_W-1:0] SPEED_STEP = 7'd42;
  localparam logic [RC_W-1:0]  RC_CENTER  = 11'd1500;

  localparam logic [CFG_AW-1:0] REG_TRIG_LOW  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TRIG_HIGH = 3'd1;
  localparam logic [CFG_AW-1:0] REG_REVERSE   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BRAKE     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_IDLE      = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FULL      = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MARGIN    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_FILTER    = 3'd7;

  localparam logic [SAMPLE_BITS-1:0] RST_TRIG_LOW  = SAMPLE_BITS'(200);
  localparam logic [SAMPLE_BITS-1:0] RST_TRIG_HIGH = SAMPLE_BITS'(900);
  localparam logic [TH_W-1:0]        RST_BRAKE     = 16'd22938;
  localparam logic [TH_W-1:0]        RST_IDLE      = 16'd42598;
  localparam logic [TH_W-1:0]        RST_FULL      = 16'd62259;
  localparam logic [TH_W-1:0]        RST_MARGIN    = 16'd32768;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] trig_low;
    logic [SAMPLE_BITS-1:0] trig_high;
    logic                   reverse_enable;
    logic [TH_W-1:0]        brake_threshold;
    logic [TH_W-1:0]        idle_threshold;
    logic [TH_W-1:0]        full_threshold;
    logic [TH_W-1:0]        bad_margin;
    logic                   filter_enable;
  } cfg_t;

  // One classified item on its way from the front part to the back part.
  typedef struct packed {
    logic             send;
    logic             div_en;
    logic             neg;
    logic [DV_W-1:0]  dividend;
    logic [TH_W-1:0]  divisor;
    logic [THR_W-1:0] thr_const;
    logic [SPD_W-1:0] speed;
    logic             fault;
  } qent_t;

endpackage

// ===== rtl/ttm_front.sv =====
// Front part: takes samples, normalizes them with a pipelined divider and classifies the zone.
module ttm_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ttm_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ttm_pkg::SAMPLE_BITS-1:0] raw_angle,
  input  logic [ttm_pkg::SPD_W-1:0]       switch_bits,
  output logic                            push,
  output ttm_pkg::qent_t                  push_data,
  input  logic                            q_full
);
  import ttm_pkg::*;

  localparam int NST = QW + 3;
  localparam int SB  = SAMPLE_BITS;

  localparam logic [1:0] ZN_BRAKE = 2'd0;
  localparam logic [1:0] ZN_IDLE  = 2'd1;
  localparam logic [1:0] ZN_PART  = 2'd2;
  localparam logic [1:0] ZN_FULL  = 2'd3;

  typedef struct packed {
    logic             qneg;
    logic [SPD_W-1:0] speed;
    logic             fault;
  } fstg_t;

  typedef struct packed {
    logic             send;
    logic [1:0]       zone;
    logic [FR_W-1:0]  fc;
    logic [SPD_W-1:0] speed;
    logic             fault;
  } cls_t;

  logic            adv;
  logic [NST-1:0]  v_r;
  logic [SB-1:0]   smp;
  logic [SB:0]     diff;
  logic [SB:0]     span;
  logic [SB-1:0]   dmag;
  logic [SB-1:0]   smag;
  logic            span_zero;
  fstg_t           st_in;

  logic [SB-1:0]   rem_r [0:QW-1];
  logic [QW-1:0]   nq_r  [0:QW];
  fstg_t           st_r  [0:QW];
  logic [SB:0]     step_rs  [0:QW-1];
  logic [SB:0]     step_rd  [0:QW-1];
  logic            step_ge  [0:QW-1];
  logic [SB-1:0]   step_rem [0:QW-1];
  logic [QW-1:0]   step_nq  [0:QW-1];

  logic [QW-1:0]   q;
  logic            qneg;
  logic [FR_W-1:0] hi_lim;
  logic            q_gt_m;
  logic            q_gt_h;
  logic            q_gt_one;
  logic            reject;
  cls_t            cls_nxt;
  cls_t            cls_r;

  logic [MUL_W-1:0] sp42;
  logic [TH_W-1:0]  d_brk;
  logic [TH_W-1:0]  d_par;
  logic [DV_W-1:0]  prod;
  qent_t            p_nxt;
  qent_t            p_r;

  assign adv      = !(v_r[NST-1] && q_full);
  assign in_ready = adv;
  assign push     = v_r[NST-1] && !q_full;
  assign push_data = p_r;

  assign smp       = cfg.reverse_enable ? ~raw_angle : raw_angle;
  assign diff      = {1'b0, smp} - {1'b0, cfg.trig_low};
  assign span      = {1'b0, cfg.trig_high} - {1'b0, cfg.trig_low};
  assign dmag      = diff[SB] ? (~diff[SB-1:0] + 1'b1) : diff[SB-1:0];
  assign smag      = span[SB] ? (~span[SB-1:0] + 1'b1) : span[SB-1:0];
  assign span_zero = (cfg.trig_low == cfg.trig_high);

  always_comb begin
    st_in.qneg  = diff[SB] ^ span[SB];
    st_in.speed = (switch_bits == '0) ? SPD_W'(1) : switch_bits;
    st_in.fault = (switch_bits == '0);
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      step_rs[k]  = {rem_r[k], nq_r[k][QW-1]};
      step_rd[k]  = step_rs[k] - {1'b0, smag};
      step_ge[k]  = (step_rs[k] >= {1'b0, smag});
      step_rem[k] = step_ge[k] ? step_rd[k][SB-1:0] : step_rs[k][SB-1:0];
      step_nq[k]  = {nq_r[k][QW-2:0], step_ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= '0;
      nq_r[0]  <= {dmag, {Q_FRAC{1'b0}}};
      st_r[0]  <= st_in;
      for (int k = 0; k < QW; k++) begin
        nq_r[k+1] <= step_nq[k];
        st_r[k+1] <= st_r[k];
      end
      for (int k = 0; k < QW - 1; k++) begin
        rem_r[k+1] <= step_rem[k];
      end
    end
  end

  assign q        = nq_r[QW];
  assign qneg     = st_r[QW].qneg;
  assign hi_lim   = {1'b0, cfg.bad_margin} + Q_ONE;
  assign q_gt_m   = (q > QW'(cfg.bad_margin));
  assign q_gt_h   = (q > QW'(hi_lim));
  assign q_gt_one = (q > QW'(Q_ONE));
  assign reject   = cfg.filter_enable && (qneg ? q_gt_m : q_gt_h);

  always_comb begin
    cls_nxt.send  = !span_zero && !reject;
    cls_nxt.speed = st_r[QW].speed;
    cls_nxt.fault = st_r[QW].fault;
    if (qneg) begin
      cls_nxt.fc = '0;
    end else if (q_gt_one) begin
      cls_nxt.fc = Q_ONE;
    end else begin
      cls_nxt.fc = q[FR_W-1:0];
    end
    if (cls_nxt.fc < {1'b0, cfg.brake_threshold}) begin
      cls_nxt.zone = ZN_BRAKE;
    end else if (cls_nxt.fc < {1'b0, cfg.idle_threshold}) begin
      cls_nxt.zone = ZN_IDLE;
    end else if (cls_nxt.fc < {1'b0, cfg.full_threshold}) begin
      cls_nxt.zone = ZN_PART;
    end else begin
      cls_nxt.zone = ZN_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_r <= cls_nxt;
    end
  end

  assign sp42  = MUL_W'(cls_r.speed) * SPEED_STEP;
  assign d_brk = cfg.brake_threshold - cls_r.fc[TH_W-1:0];
  assign d_par = cls_r.fc[TH_W-1:0] - cfg.idle_threshold;
  assign prod  = DV_W'(d_par) * DV_W'(sp42);

  always_comb begin
    p_nxt.send      = cls_r.send;
    p_nxt.speed     = cls_r.speed;
    p_nxt.fault     = cls_r.fault;
    p_nxt.div_en    = 1'b0;
    p_nxt.neg       = 1'b0;
    p_nxt.dividend  = '0;
    p_nxt.divisor   = '0;
    p_nxt.thr_const = '0;
    if (cls_r.send) begin
      unique case (cls_r.zone)
        ZN_BRAKE: begin
          p_nxt.div_en   = 1'b1;
          p_nxt.neg      = 1'b1;
          p_nxt.dividend = {d_brk, {BRAKE_SH{1'b0}}};
          p_nxt.divisor  = cfg.brake_threshold;
        end
        ZN_PART: begin
          p_nxt.div_en   = 1'b1;
          p_nxt.dividend = prod;
          p_nxt.divisor  = cfg.full_threshold - cfg.idle_threshold;
        end
        ZN_FULL: begin
          p_nxt.thr_const = {1'b0, sp42} + 1'b1;
        end
        default: begin
          p_nxt.thr_const = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= p_nxt;
    end
  end

endmodule

// ===== rtl/ttm_fifo.sv =====
// Short first-word-fall-through queue between the front and back parts.
module ttm_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttm_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output ttm_pkg::qent_t head,
  output logic           empty
);
  import ttm_pkg::*;

  qent_t            mem_r [0:QD-1];
  logic [QP_W-1:0]  wptr_r;
  logic [QP_W-1:0]  wptr_nxt;
  logic [QP_W-1:0]  rptr_r;
  logic [QP_W-1:0]  rptr_nxt;
  logic [QC_W-1:0]  cnt_r;
  logic [QC_W-1:0]  cnt_nxt;

  assign full  = (cnt_r == QC_W'(QD));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/ttm_back.sv =====
// Back part: pipelined zone division, sign and channel offset, and the output register.
module ttm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ttm_pkg::qent_t             head,
  input  logic                       q_empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_send,
  output logic [ttm_pkg::THR_W-1:0]  out_throttle,
  output logic [ttm_pkg::RC_W-1:0]   out_rc_value,
  output logic [ttm_pkg::SPD_W-1:0]  out_speed,
  output logic                       out_fault
);
  import ttm_pkg::*;

  typedef struct packed {
    logic             send;
    logic             div_en;
    logic             neg;
    logic [TH_W-1:0]  divisor;
    logic [THR_W-1:0] thr_const;
    logic [SPD_W-1:0] speed;
    logic             fault;
  } bstg_t;

  logic            adv;
  logic [DQ-1:0]   v_r;
  logic [TH_W-1:0] rem_r [0:DQ-1];
  logic [DQ-1:0]   nq_r  [0:DQ-1];
  bstg_t           st_r  [0:DQ-1];
  logic [TH_W-1:0] cur_rem [0:DQ-1];
  logic [DQ-1:0]   cur_nq  [0:DQ-1];
  bstg_t           cur_st  [0:DQ-1];
  logic [TH_W:0]   step_rs [0:DQ-1];
  logic [TH_W:0]   step_rd [0:DQ-1];
  logic            step_ge [0:DQ-1];

  bstg_t            last;
  logic [DQ-1:0]    quo;
  logic [THR_W-1:0] thr;
  logic             out_valid_r;
  logic             out_send_r;
  logic [THR_W-1:0] out_thr_r;
  logic [RC_W-1:0]  out_rc_r;
  logic [SPD_W-1:0] out_speed_r;
  logic             out_fault_r;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_empty;

  always_comb begin
    cur_rem[0]          = TH_W'(head.dividend >> DQ);
    cur_nq[0]           = head.dividend[DQ-1:0];
    cur_st[0].send      = head.send;
    cur_st[0].div_en    = head.div_en;
    cur_st[0].neg       = head.neg;
    cur_st[0].divisor   = head.divisor;
    cur_st[0].thr_const = head.thr_const;
    cur_st[0].speed     = head.speed;
    cur_st[0].fault     = head.fault;
    for (int k = 1; k < DQ; k++) begin
      cur_rem[k] = rem_r[k-1];
      cur_nq[k]  = nq_r[k-1];
      cur_st[k]  = st_r[k-1];
    end
    for (int k = 0; k < DQ; k++) begin
      step_rs[k] = {cur_rem[k], cur_nq[k][DQ-1]};
      step_rd[k] = step_rs[k] - {1'b0, cur_st[k].divisor};
      step_ge[k] = (step_rs[k] >= {1'b0, cur_st[k].divisor});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DQ-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DQ; k++) begin
        rem_r[k] <= step_ge[k] ? step_rd[k][TH_W-1:0] : step_rs[k][TH_W-1:0];
        nq_r[k]  <= {cur_nq[k][DQ-2:0], step_ge[k]};
        st_r[k]  <= cur_st[k];
      end
    end
  end

  assign last = st_r[DQ-1];
  assign quo  = nq_r[DQ-1];

  always_comb begin
    if (!last.div_en) begin
      thr = last.thr_const;
    end else if (last.neg) begin
      thr = ~THR_W'(quo) + 1'b1;
    end else begin
      thr = THR_W'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[DQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_send_r  <= last.send;
      out_thr_r   <= thr;
      out_rc_r    <= RC_CENTER + {{(RC_W-THR_W){thr[THR_W-1]}}, thr};
      out_speed_r <= last.speed;
      out_fault_r <= last.fault;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_send     = out_send_r;
  assign out_throttle = out_thr_r;
  assign out_rc_value = out_rc_r;
  assign out_speed    = out_speed_r;
  assign out_fault    = out_fault_r;

endmodule

// ===== rtl/trigger_to_throttle_mapper_top.sv =====
// Top level of the trigger to throttle mapper: configuration registers and stream ports.
//
// Each trigger sample transfer produces exactly one result transfer. One sample is
// accepted every clock cycle while the result stream does not back-pressure the
// pipeline. A sample passes through the fully pipelined dividers: one quotient bit
// per stage for the normalization (sample width plus 16 stages) and eight stages
// for the zone scaling, with the queue between the two halves. Results keep the
// order of the samples. The configuration registers may only be rewritten while no
// sample is in flight.
module trigger_to_throttle_mapper_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // Fields from bit 0: raw_angle, switch_bits, zero fill.
  input  logic [ttm_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // Fields from bit 0: throttle, rc_value, speed_level, switch_fault, zero fill.
  output logic [ttm_pkg::OUT_W-1:0]    out_tdata,
  // Fields from bit 0: send.
  output logic                         out_tuser,
  input  logic                         cfg_we,
  input  logic [ttm_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [ttm_pkg::CFG_DW-1:0]   cfg_wdata
);
  import ttm_pkg::*;

  cfg_t             cfg_r;
  logic             push;
  qent_t            push_data;
  logic             q_full;
  logic             pop;
  qent_t            head;
  logic             q_empty;
  logic             o_send;
  logic [THR_W-1:0] o_thr;
  logic [RC_W-1:0]  o_rc;
  logic [SPD_W-1:0] o_speed;
  logic             o_fault;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_low        <= RST_TRIG_LOW;
      cfg_r.trig_high       <= RST_TRIG_HIGH;
      cfg_r.reverse_enable  <= 1'b1;
      cfg_r.brake_threshold <= RST_BRAKE;
      cfg_r.idle_threshold  <= RST_IDLE;
      cfg_r.full_threshold  <= RST_FULL;
      cfg_r.bad_margin      <= RST_MARGIN;
      cfg_r.filter_enable   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TRIG_LOW:  cfg_r.trig_low        <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_TRIG_HIGH: cfg_r.trig_high       <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_REVERSE:   cfg_r.reverse_enable  <= cfg_wdata[0];
        REG_BRAKE:     cfg_r.brake_threshold <= cfg_wdata[TH_W-1:0];
        REG_IDLE:      cfg_r.idle_threshold  <= cfg_wdata[TH_W-1:0];
        REG_FULL:      cfg_r.full_threshold  <= cfg_wdata[TH_W-1:0];
        REG_MARGIN:    cfg_r.bad_margin      <= cfg_wdata[TH_W-1:0];
        REG_FILTER:    cfg_r.filter_enable   <= cfg_wdata[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  ttm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .raw_angle   (in_tdata[SAMPLE_BITS-1:0]),
    .switch_bits (in_tdata[SAMPLE_BITS+SPD_W-1:SAMPLE_BITS]),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  ttm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  ttm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_send     (o_send),
    .out_throttle (o_thr),
    .out_rc_value (o_rc),
    .out_speed    (o_speed),
    .out_fault    (o_fault)
  );

  assign out_tuser = o_send;
  assign out_tdata = {{(OUT_W-THR_W-RC_W-SPD_W-1){1'b0}}, o_fault, o_speed, o_rc, o_thr};

endmodule

// ===== tb/trigger_to_throttle_mapper_top_tb.sv =====
// Self-checking testbench of the trigger to throttle mapper top level.
module trigger_to_throttle_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttm_pkg::*;

  localparam longint FULL_SCALE = (longint'(1) << SAMPLE_BITS) - 1;
  localparam longint Q_UNIT     = longint'(1) << Q_FRAC;
  localparam longint STEP       = 42;
  localparam longint BRAKE_SPAN = 128;
  localparam longint CENTER     = 1500;
  localparam int     IDLE_PCT   = 23;
  localparam int     PHASE_LEN  = 112;
  localparam int     DRAIN_WAIT = 48;

  typedef struct packed {
    logic [SPD_W-1:0]       sw;
    logic [SAMPLE_BITS-1:0] angle;
  } sample_t;

  typedef struct packed {
    logic                    send;
    logic signed [THR_W-1:0] throttle;
    logic [RC_W-1:0]         rc_value;
    logic [SPD_W-1:0]        speed_level;
    logic                    switch_fault;
  } command_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  cfg_t     cal;
  sample_t  queued_samples[$];
  command_t expected_commands[$];
  sample_t  on_bus;
  bit       send_next;
  bit       steady = 1'b0;
  bit       hold_sender = 1'b0;
  int       mismatches = 0;

  trigger_to_throttle_mapper_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic command_t predict_command(input sample_t s);
    command_t c;
    longint   pos;
    longint   lo;
    longint   hi;
    longint   span;
    longint   frac;
    longint   margin;
    longint   brk;
    longint   idl;
    longint   ful;
    longint   spd;
    longint   thr;
    longint   rc;
    spd = (s.sw == 2'd0) ? 1 : longint'(s.sw);
    c.switch_fault = (s.sw == 2'd0);
    c.speed_level = spd[SPD_W-1:0];
    pos = s.angle;
    if (cal.reverse_enable) begin
      pos = FULL_SCALE - pos;
    end
    lo = cal.trig_low;
    hi = cal.trig_high;
    span = hi - lo;
    margin = cal.bad_margin;
    brk = cal.brake_threshold;
    idl = cal.idle_threshold;
    ful = cal.full_threshold;
    thr = 0;
    c.send = 1'b1;
    if (span == 0) begin
      c.send = 1'b0;
    end else begin
      frac = ((pos - lo) * Q_UNIT) / span;
      if (cal.filter_enable && (frac < -margin || frac > Q_UNIT + margin)) begin
        c.send = 1'b0;
      end else begin
        if (frac < 0) frac = 0;
        if (frac > Q_UNIT) frac = Q_UNIT;
        if (frac < brk) begin
          thr = ((frac - brk) * BRAKE_SPAN) / brk;
        end else if (frac < idl) begin
          thr = 0;
        end else if (frac < ful) begin
          thr = ((frac - idl) * spd * STEP) / (ful - idl);
        end else begin
          thr = spd * STEP + 1;
        end
      end
    end
    rc = CENTER + thr;
    c.throttle = thr[THR_W-1:0];
    c.rc_value = rc[RC_W-1:0];
    return c;
  endfunction

  // Most samples land near the calibrated window so that every zone is reached.
  function automatic sample_t draw_sample();
    sample_t s;
    int      lo;
    int      hi;
    int      w;
    int      a;
    int      roll;
    lo = (cal.trig_low < cal.trig_high) ? cal.trig_low : cal.trig_high;
    hi = (cal.trig_low < cal.trig_high) ? cal.trig_high : cal.trig_low;
    w = (hi - lo) / 2 + 8;
    roll = $urandom_range(99);
    s.sw = SPD_W'($urandom_range(3));
    if (roll < 8) begin
      case ($urandom_range(3))
        0: a = 0;
        1: a = int'(FULL_SCALE);
        2: a = cal.trig_low;
        default: a = cal.trig_high;
      endcase
    end else if (roll < 70) begin
      a = $urandom_range((hi + w > FULL_SCALE) ? int'(FULL_SCALE) : hi + w,
                         (lo - w < 0) ? 0 : lo - w);
    end else begin
      a = $urandom_range(int'(FULL_SCALE));
    end
    if (roll < 70 && cal.reverse_enable) begin
      a = int'(FULL_SCALE) - a;
    end
    s.angle = SAMPLE_BITS'(a);
    return s;
  endfunction

  function automatic cfg_t random_cal();
    cfg_t        c;
    logic [15:0] t0;
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] tmp;
    t0 = 16'($urandom);
    t1 = 16'($urandom);
    t2 = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
      if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
      if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
    end
    c.trig_low = SAMPLE_BITS'($urandom);
    c.trig_high = SAMPLE_BITS'($urandom);
    c.reverse_enable = 1'($urandom);
    c.brake_threshold = t0;
    c.idle_threshold = t1;
    c.full_threshold = t2;
    c.bad_margin = 16'($urandom);
    c.filter_enable = 1'($urandom);
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_cal(input cfg_t c);
    write_reg(REG_TRIG_LOW, CFG_DW'(c.trig_low));
    write_reg(REG_TRIG_HIGH, CFG_DW'(c.trig_high));
    write_reg(REG_REVERSE, CFG_DW'(c.reverse_enable));
    write_reg(REG_BRAKE, c.brake_threshold);
    write_reg(REG_IDLE, c.idle_threshold);
    write_reg(REG_FULL, c.full_threshold);
    write_reg(REG_MARGIN, c.bad_margin);
    write_reg(REG_FILTER, CFG_DW'(c.filter_enable));
    cal = c;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (queued_samples.size() != 0 || in_tvalid || expected_commands.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(input int n, input bit pause_mid);
    for (int i = 0; i < n; i++) begin
      queued_samples.push_back(draw_sample());
    end
    if (pause_mid) begin
      while (queued_samples.size() > n / 2) @(negedge clk);
      hold_sender = 1'b1;
      while (in_tvalid || expected_commands.size() != 0) @(negedge clk);
      hold_sender = 1'b0;
    end
    wait_idle();
  endtask

  task automatic report_field(input string field, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s: expected %0d, got %0d", field, want, got);
      end
    end
  endtask

  // The item on the bus stays there until its transfer completes.
  always @(posedge clk) begin
    send_next = in_tvalid;
    if (in_tvalid && in_tready) begin
      expected_commands.push_back(predict_command(on_bus));
      send_next = 1'b0;
    end
    if (!send_next && rst_n && !hold_sender && queued_samples.size() != 0 &&
        (steady || $urandom_range(99) >= IDLE_PCT)) begin
      on_bus = queued_samples.pop_front();
      in_tdata <= IN_W'({on_bus.sw, on_bus.angle});
      send_next = 1'b1;
    end
    in_tvalid <= send_next;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_commands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result transfer: tdata %h, tuser %b", out_tdata, out_tuser);
        end
      end else begin
        command_t want;
        want = expected_commands.pop_front();
        report_field("send", want.send, out_tuser);
        report_field("throttle", want.throttle, $signed(out_tdata[7:0]));
        report_field("rc_value", want.rc_value, out_tdata[18:8]);
        report_field("speed_level", want.speed_level, out_tdata[20:19]);
        report_field("switch_fault", want.switch_fault, out_tdata[21]);
      end
    end
    out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
  end

  initial begin
    #2_000_000;
    $display("trigger_to_throttle_mapper_top_tb: FAIL");
    $finish;
  end

  initial begin
    int angles[6];
    angles = '{0, 4095, 3895, 3195, 3700, 3300};
    cal = '{RST_TRIG_LOW, RST_TRIG_HIGH, 1'b1, RST_BRAKE, RST_IDLE, RST_FULL,
            RST_MARGIN, 1'b1};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (angles[i]) begin
      for (int sw = 0; sw < 4; sw++) begin
        queued_samples.push_back('{SPD_W'(sw), SAMPLE_BITS'(angles[i])});
      end
    end
    wait_idle();

    apply_cal('{12'd200, 12'd900, 1'b1, 16'd22938, 16'd42598, 16'd62259, 16'd32768, 1'b1});
    run_phase(PHASE_LEN, 1'b0);

    steady = 1'b1;
    apply_cal('{12'd0, 12'd4095, 1'b0, 16'd65535, 16'd65535, 16'd65535, 16'd0, 1'b1});
    run_phase(PHASE_LEN, 1'b0);
    steady = 1'b0;

    // Reversed limits: the fraction falls as the sample rises.
    apply_cal('{12'd3000, 12'd1000, 1'b0, 16'd10000, 16'd30000, 16'd50000, 16'd65535, 1'b1});
    run_phase(PHASE_LEN, 1'b1);

    // Zero span rejects everything, filter or not.
    apply_cal('{12'd1234, 12'd1234, 1'b1, 16'd1, 16'd2, 16'd3, 16'd0, 1'b0});
    run_phase(PHASE_LEN, 1'b0);

    apply_cal('{12'd100, 12'd4000, 1'b0, 16'd50000, 16'd20000, 16'd10000, 16'd0, 1'b0});
    run_phase(PHASE_LEN, 1'b0);

    // Zero brake threshold never brakes.
    apply_cal('{12'd500, 12'd3500, 1'b1, 16'd0, 16'd1, 16'd65535, 16'd100, 1'b1});
    run_phase(PHASE_LEN, 1'b0);

    apply_cal('{12'd2000, 12'd2001, 1'b0, 16'd30000, 16'd31000, 16'd32000, 16'd1000, 1'b1});
    run_phase(PHASE_LEN, 1'b0);

    repeat (5) begin
      apply_cal(random_cal());
      run_phase(PHASE_LEN, 1'b0);
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_commands.size() == 0) begin
      $display("trigger_to_throttle_mapper_top_tb: PASS");
    end else begin
      $display("trigger_to_throttle_mapper_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ttm_pkg.sv
rtl/ttm_front.sv
rtl/ttm_fifo.sv
rtl/ttm_back.sv
rtl/trigger_to_throttle_mapper_top.sv
tb/trigger_to_throttle_mapper_top_tb.sv
